FILE: hw/rtl/ilist_pkg.sv
// Shared types and constants for the indexed list block.
package ilist_pkg;

   localparam int DEPTH  = 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_APPEND = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_ERASE  = 3'd2,
      CMD_READ   = 3'd3,
      CMD_FIRST  = 3'd4,
      CMD_LAST   = 3'd5
   } cmd_type;

   // unused command codes, answered at once with no effect
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ILI_IDLE,
      ILI_READ,
      ILI_UP,
      ILI_INS,
      ILI_DOWN
   } state_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [8:0]         position;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      status_type         status;
      logic [8:0]         element_count;
      logic               is_empty;
   } rsp_type;

endpackage

FILE: hw/rtl/indexed_list_insert_erase.sv
// Indexed list: append, insert, erase, read, first and last over a one-port-write memory.
// Append, insert at the end, erase of the last element, failed requests and unused codes
// answer in the cycle after accept; reads pass the memory output and READ state. Insert
// below the count walks UP, then INS; erase walks DOWN. Busy holds until the result cycle,
// in which the next item may be accepted; the shift walks the memory one element a cycle.
// Reset clears count, sequencer and strobe, not the element memory; results cannot stall.
module indexed_list_insert_erase (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ilist_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ilist_pkg::rsp_type rsp_data
);
   import ilist_pkg::*;

   logic [31:0]       mem [DEPTH];
   logic [31:0]       mem_q_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [31:0]       mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;

   status_type        dec_status;
   logic              dec_quick;
   logic              is_full;
   logic [ADDR_W-1:0] last_idx;
   logic [ADDR_W-1:0] pos_idx;
   logic              up_last;
   logic              dn_last;
   logic signed [31:0] rd_value;
   status_type        rsp_status;

   assign is_full  = (32'(count_ff) >= DEPTH);
   assign last_idx = ADDR_W'(count_ff - 1'b1);
   assign pos_idx  = req_ff.position[ADDR_W-1:0];
   assign up_last  = (idx_ff == pos_idx);
   assign dn_last  = (idx_ff == last_idx);

   // Classify an incoming item: fail status, and whether it finishes at accept.
   always_comb begin
      dec_status = ST_OK;
      dec_quick  = 1'b1;
      case (req_data.cmd)
         CMD_APPEND: begin
            if (is_full) dec_status = ST_FULL;
         end
         CMD_INSERT: begin
            if (32'(req_data.position) > 32'(count_ff)) begin
               dec_status = ST_RANGE;
            end else if (is_full) begin
               dec_status = ST_FULL;
            end else if (32'(req_data.position) != 32'(count_ff)) begin
               dec_quick = 1'b0;
            end
         end
         CMD_ERASE: begin
            if (32'(req_data.position) >= 32'(count_ff)) begin
               dec_status = ST_RANGE;
            end else if (32'(req_data.position) + 1 != 32'(count_ff)) begin
               dec_quick = 1'b0;
            end
         end
         CMD_READ: begin
            if (32'(req_data.position) >= 32'(count_ff)) dec_status = ST_RANGE;
            else dec_quick = 1'b0;
         end
         CMD_FIRST, CMD_LAST: begin
            if (count_ff == '0) dec_status = ST_EMPTY;
            else dec_quick = 1'b0;
         end
         default: begin
            dec_quick = 1'b1;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ILI_IDLE: begin
            if (start && !dec_quick) begin
               case (req_data.cmd)
                  CMD_INSERT: state_in = ILI_UP;
                  CMD_ERASE:  state_in = ILI_DOWN;
                  default:    state_in = ILI_READ;
               endcase
            end
         end
         ILI_READ: state_in = ILI_IDLE;
         ILI_UP: begin
            if (up_last) state_in = ILI_INS;
         end
         ILI_INS: state_in = ILI_IDLE;
         ILI_DOWN: begin
            if (dn_last) state_in = ILI_IDLE;
         end
         default: state_in = ILI_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = idx_ff;
      mem_wdata  = mem_q_ff;
      mem_raddr  = idx_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      req_in     = req_ff;
      strobe_in  = 1'b0;
      rd_value   = '0;
      rsp_status = ST_OK;
      case (state_ff)
         ILI_IDLE: begin
            if (start) begin
               req_in     = req_data;
               rsp_status = dec_status;
               strobe_in  = dec_quick;
               case (req_data.cmd)
                  CMD_APPEND: begin
                     if (dec_status == ST_OK) begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[ADDR_W-1:0];
                        mem_wdata = req_data.item_value;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  CMD_INSERT: begin
                     if (dec_status == ST_OK && dec_quick) begin
                        // insert at the end acts as append
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[ADDR_W-1:0];
                        mem_wdata = req_data.item_value;
                        count_in  = count_ff + 1'b1;
                     end else begin
                        mem_raddr = last_idx;
                        idx_in    = last_idx;
                     end
                  end
                  CMD_ERASE: begin
                     if (dec_status == ST_OK && dec_quick) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        mem_raddr = ADDR_W'(req_data.position + 1'b1);
                        idx_in    = ADDR_W'(req_data.position + 1'b1);
                     end
                  end
                  CMD_READ:  mem_raddr = req_data.position[ADDR_W-1:0];
                  CMD_FIRST: mem_raddr = '0;
                  CMD_LAST:  mem_raddr = last_idx;
                  default: begin
                     mem_raddr = idx_ff;
                  end
               endcase
            end
         end
         ILI_READ: begin
            rd_value  = mem_q_ff;
            strobe_in = 1'b1;
         end
         ILI_UP: begin
            // move element idx up one place, then fetch the one below
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(idx_ff + 1'b1);
            mem_raddr = ADDR_W'(idx_ff - 1'b1);
            if (!up_last) idx_in = ADDR_W'(idx_ff - 1'b1);
         end
         ILI_INS: begin
            mem_we    = 1'b1;
            mem_waddr = pos_idx;
            mem_wdata = req_ff.item_value;
            count_in  = count_ff + 1'b1;
            strobe_in = 1'b1;
         end
         ILI_DOWN: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(idx_ff - 1'b1);
            mem_raddr = ADDR_W'(idx_ff + 1'b1);
            if (dn_last) begin
               count_in  = count_ff - 1'b1;
               strobe_in = 1'b1;
            end else begin
               idx_in = ADDR_W'(idx_ff + 1'b1);
            end
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
      rsp_in.read_value    = rd_value;
      rsp_in.status        = rsp_status;
      rsp_in.element_count = 9'(count_in);
      rsp_in.is_empty      = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_q_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ILI_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ILI_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

FILE: hw/rtl/ilist_check.sv
// Port-level assertions for the indexed list block, bound to the top level.
module ilist_check (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input ilist_pkg::req_type req_data,
   input logic               rsp_strobe,
   input ilist_pkg::rsp_type rsp_data
);
   import ilist_pkg::*;

   // a result never shows while a shift is still running
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.is_empty == (rsp_data.element_count == '0)))
      else $error("empty flag disagrees with count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_data.element_count) <= DEPTH))
      else $error("count beyond capacity");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status != ST_OK) |-> (rsp_data.read_value == '0))
      else $error("failed item returned data");

   // an append or unused code answers in the next cycle
   a_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.cmd == CMD_APPEND || req_data.cmd == CMD_SPARE_LO ||
       req_data.cmd == CMD_SPARE_HI)) |=> rsp_strobe)
      else $error("missing quick result");

endmodule

bind indexed_list_insert_erase ilist_check u_ilist_check (.*);
